>>> rtl/tvsg_pkg.sv
// ----------------------------------------------------------------------------
// tvsg_pkg
// Shared types and constants of the three-voice sound generator: bus
// operation codes, envelope direction codes, register indexes and word types.
// ----------------------------------------------------------------------------
package tvsg_pkg;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_LATCH = 2'd1,
		OP_WRITE = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_UP   = 2'd1,
		DIR_DOWN = 2'd2
	} env_dir_t;

	localparam int unsigned NUM_REGS  = 16;
	localparam int unsigned NUM_VOICE = 3;

	localparam logic [3:0] REG_MIXER   = 4'd7;
	localparam logic [3:0] REG_NOISE   = 4'd6;
	localparam logic [3:0] REG_ENV_LO  = 4'd11;
	localparam logic [3:0] REG_ENV_HI  = 4'd12;
	localparam logic [3:0] REG_ENV_SHP = 4'd13;
	localparam logic [3:0] REG_PORT    = 4'd14;
	localparam int unsigned REG_VOL0   = 8;

	// envelope shape bits of the shape register
	localparam int unsigned SHP_HOLD   = 0;
	localparam int unsigned SHP_ALT    = 1;
	localparam int unsigned SHP_ATTACK = 2;
	localparam int unsigned SHP_CONT   = 3;

	localparam logic [4:0] ENV_PRE_LAST = 5'd16;
	localparam logic [3:0] LEVEL_MAX    = 4'd15;
	localparam logic [7:0] NOISE_MASK   = 8'h1F;
	localparam logic [16:0] LFSR_SEED   = 17'd1;

	typedef struct packed {
		op_t        operation;
		logic [7:0] data_in;
		logic [7:0] port_in;
		logic       tape_in;
	} in_item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       sample_valid;
		logic       gate_a;
		logic       gate_b;
		logic       gate_c;
		logic [3:0] volume_a;
		logic [3:0] volume_b;
		logic [3:0] volume_c;
		logic       tape_out;
	} out_item_t;

endpackage

>>> rtl/tvsg_if.sv
// ----------------------------------------------------------------------------
// tvsg interfaces
// Valid/ready channels carrying bus words into the block and result words out.
// ----------------------------------------------------------------------------
interface tvsg_in_if;
	logic              valid;
	logic              ready;
	tvsg_pkg::in_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface tvsg_out_if;
	logic               valid;
	logic               ready;
	tvsg_pkg::out_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/tvsg_core.sv
// ----------------------------------------------------------------------------
// tvsg_core
// Chip state of the sound generator: register file, tone, noise and envelope
// generators. Applies one bus word per enabled cycle and forms its result.
// ----------------------------------------------------------------------------
module tvsg_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  tvsg_pkg::in_item_t  item,
	output tvsg_pkg::out_item_t result
);

	logic [7:0]  regs_q [tvsg_pkg::NUM_REGS];
	logic [7:0]  regs_n [tvsg_pkg::NUM_REGS];
	logic [3:0]  addr_q, addr_n;
	logic [7:0]  latch_q, latch_n;
	logic [11:0] tone_cnt_q [tvsg_pkg::NUM_VOICE];
	logic [11:0] tone_cnt_n [tvsg_pkg::NUM_VOICE];
	logic [2:0]  tone_bit_q, tone_bit_n;
	logic [3:0]  tone_pre_q, tone_pre_n;
	logic [4:0]  env_pre_q, env_pre_n;
	logic [15:0] env_cnt_q, env_cnt_n;
	logic [3:0]  env_lvl_q, env_lvl_n;
	tvsg_pkg::env_dir_t env_dir_q, env_dir_n;
	logic        env_run_q, env_run_n;
	logic [7:0]  noise_cnt_q, noise_cnt_n;
	logic        noise_bit_q, noise_bit_n;
	logic [16:0] lfsr_q, lfsr_n;
	logic        sample_n;

	always_comb begin
		logic [10:0] period;
		logic [11:0] cnt;
		logic [7:0]  shp;
		regs_n      = regs_q;
		addr_n      = addr_q;
		latch_n     = latch_q;
		tone_cnt_n  = tone_cnt_q;
		tone_bit_n  = tone_bit_q;
		tone_pre_n  = tone_pre_q;
		env_pre_n   = env_pre_q;
		env_cnt_n   = env_cnt_q;
		env_lvl_n   = env_lvl_q;
		env_dir_n   = env_dir_q;
		env_run_n   = env_run_q;
		noise_cnt_n = noise_cnt_q;
		noise_bit_n = noise_bit_q;
		lfsr_n      = lfsr_q;
		sample_n    = 1'b0;
		shp         = regs_q[tvsg_pkg::REG_ENV_SHP];
		if (en) begin
			case (item.operation)
				tvsg_pkg::OP_TICK: begin
					if (env_run_q) begin
						if (env_pre_q == tvsg_pkg::ENV_PRE_LAST) begin
							env_pre_n = '0;
							env_cnt_n = env_cnt_q - 16'd1;
							if (env_cnt_n == '0) begin
								env_cnt_n = {regs_q[tvsg_pkg::REG_ENV_HI],
									regs_q[tvsg_pkg::REG_ENV_LO]};
								case (env_dir_q)
									tvsg_pkg::DIR_UP: begin
										env_lvl_n = env_lvl_q + 4'd1;
										if (env_lvl_n == tvsg_pkg::LEVEL_MAX) begin
											if (!shp[tvsg_pkg::SHP_CONT]) begin
												env_run_n = 1'b0;
												env_lvl_n = '0;
											end else if (shp[tvsg_pkg::SHP_HOLD]) begin
												env_run_n = 1'b0;
												if (shp[tvsg_pkg::SHP_ALT])
													env_lvl_n = '0;
											end else if (shp[tvsg_pkg::SHP_ALT]) begin
												env_dir_n = tvsg_pkg::DIR_DOWN;
											end else begin
												env_lvl_n = '0;
											end
										end
									end
									tvsg_pkg::DIR_DOWN: begin
										env_lvl_n = env_lvl_q - 4'd1;
										if (env_lvl_n == '0) begin
											if (!shp[tvsg_pkg::SHP_CONT]) begin
												env_run_n = 1'b0;
												env_lvl_n = '0;
											end else if (shp[tvsg_pkg::SHP_HOLD]) begin
												env_run_n = 1'b0;
												if (shp[tvsg_pkg::SHP_ALT])
													env_lvl_n = tvsg_pkg::LEVEL_MAX;
											end else if (shp[tvsg_pkg::SHP_ALT]) begin
												env_dir_n = tvsg_pkg::DIR_UP;
											end else begin
												env_lvl_n = tvsg_pkg::LEVEL_MAX;
											end
										end
									end
									default: begin
										// no direction: level stays put
									end
								endcase
							end
						end else begin
							env_pre_n = env_pre_q + 5'd1;
						end
					end
					tone_pre_n = tone_pre_q + 4'd1;
					if (tone_pre_n == '0) begin
						sample_n    = 1'b1;
						noise_cnt_n = noise_cnt_q - 8'd1;
						if (noise_cnt_n == '0) begin
							noise_cnt_n = regs_q[tvsg_pkg::REG_NOISE] & tvsg_pkg::NOISE_MASK;
							lfsr_n      = {lfsr_q[0] ^ lfsr_q[3], lfsr_q[16:1]};
							noise_bit_n = lfsr_q[1];
						end
						for (int k = 0; k < tvsg_pkg::NUM_VOICE; k++) begin
							period = {regs_q[2*k+1][3:0], regs_q[2*k][7:1]};
							cnt    = tone_cnt_q[k] + 12'd1;
							if (cnt >= {1'b0, period}) begin
								tone_cnt_n[k] = '0;
								tone_bit_n[k] = ~tone_bit_q[k];
							end else begin
								tone_cnt_n[k] = cnt;
							end
						end
					end
				end
				tvsg_pkg::OP_LATCH: begin
					addr_n = item.data_in[3:0];
				end
				tvsg_pkg::OP_WRITE: begin
					regs_n[addr_q] = item.data_in;
					if (addr_q == tvsg_pkg::REG_NOISE) begin
						noise_cnt_n = item.data_in & tvsg_pkg::NOISE_MASK;
					end else if (addr_q == tvsg_pkg::REG_ENV_LO ||
						addr_q == tvsg_pkg::REG_ENV_HI) begin
						// period taken after this write lands
						env_cnt_n = {regs_n[tvsg_pkg::REG_ENV_HI], regs_n[tvsg_pkg::REG_ENV_LO]};
					end else if (addr_q == tvsg_pkg::REG_ENV_SHP) begin
						env_cnt_n = {regs_q[tvsg_pkg::REG_ENV_HI], regs_q[tvsg_pkg::REG_ENV_LO]};
						env_run_n = 1'b1;
						if (item.data_in[tvsg_pkg::SHP_ATTACK]) begin
							env_lvl_n = '0;
							env_dir_n = tvsg_pkg::DIR_UP;
						end else begin
							env_lvl_n = tvsg_pkg::LEVEL_MAX;
							env_dir_n = tvsg_pkg::DIR_DOWN;
						end
					end
				end
				tvsg_pkg::OP_READ: begin
					if (addr_q < tvsg_pkg::REG_PORT)
						latch_n = regs_q[addr_q];
					else if (addr_q == tvsg_pkg::REG_PORT)
						latch_n = item.port_in;
				end
				default: begin
				end
			endcase
		end
	end

	// result is formed from the state as it stands after this word
	always_comb begin
		logic [7:0] mix;
		logic [2:0] gate;
		logic [3:0] vol [tvsg_pkg::NUM_VOICE];
		mix = regs_n[tvsg_pkg::REG_MIXER];
		for (int k = 0; k < tvsg_pkg::NUM_VOICE; k++) begin
			gate[k] = (!mix[k] && tone_bit_n[k]) || (!mix[k+3] && noise_bit_n);
			vol[k]  = regs_n[tvsg_pkg::REG_VOL0+k][4] ? env_lvl_n
				: regs_n[tvsg_pkg::REG_VOL0+k][3:0];
		end
		result.read_data    = latch_n;
		result.sample_valid = sample_n;
		result.gate_a       = gate[0];
		result.gate_b       = gate[1];
		result.gate_c       = gate[2];
		result.volume_a     = vol[0];
		result.volume_b     = vol[1];
		result.volume_c     = vol[2];
		result.tape_out     = item.tape_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tvsg_pkg::NUM_REGS; i++)
				regs_q[i] <= '0;
			for (int k = 0; k < tvsg_pkg::NUM_VOICE; k++)
				tone_cnt_q[k] <= '0;
			addr_q      <= '0;
			latch_q     <= '0;
			tone_bit_q  <= '0;
			tone_pre_q  <= '0;
			env_pre_q   <= '0;
			env_cnt_q   <= '0;
			env_lvl_q   <= '0;
			env_dir_q   <= tvsg_pkg::DIR_NONE;
			env_run_q   <= 1'b0;
			noise_cnt_q <= '0;
			noise_bit_q <= 1'b0;
			lfsr_q      <= tvsg_pkg::LFSR_SEED;
		end else begin
			regs_q      <= regs_n;
			tone_cnt_q  <= tone_cnt_n;
			addr_q      <= addr_n;
			latch_q     <= latch_n;
			tone_bit_q  <= tone_bit_n;
			tone_pre_q  <= tone_pre_n;
			env_pre_q   <= env_pre_n;
			env_cnt_q   <= env_cnt_n;
			env_lvl_q   <= env_lvl_n;
			env_dir_q   <= env_dir_n;
			env_run_q   <= env_run_n;
			noise_cnt_q <= noise_cnt_n;
			noise_bit_q <= noise_bit_n;
			lfsr_q      <= lfsr_n;
		end
	end

endmodule

>>> rtl/three_voice_sound_generator_top.sv
// ----------------------------------------------------------------------------
// three_voice_sound_generator_top
// Three-voice sound generator with a 16-register bus, one result per word.
// ----------------------------------------------------------------------------
// Usage:
//  req carries bus words: a tick, an address latch, a register write or a
//  register read (register 14 returns port_in). rsp carries one result word
//  for every req word, in order: read latch, sample strobe, gate bit and
//  volume index per voice, and the tape level.
//  A req word passes through one input register, then the chip state update
//  and result register in one pass, before its result word is valid on rsp.
//  Throughput is one word per cycle while rsp does not stall.
//  Reset clears the register file and all generator state; the noise shift
//  register starts at one. Nothing is in flight after reset.
//  When rsp stalls, the result register holds and the input register fills;
//  req.ready drops only when both are occupied, and no word is lost.
// ----------------------------------------------------------------------------
module three_voice_sound_generator_top (
	input logic        clk,
	input logic        arst_n,
	tvsg_in_if.sink    req,
	tvsg_out_if.source rsp
);

	logic                valid_s1;
	tvsg_pkg::in_item_t  item_s1;
	logic                adv;
	logic                out_valid_q;
	tvsg_pkg::out_item_t out_q;
	tvsg_pkg::out_item_t result;

	assign adv       = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready)
			item_s1 <= req.payload;
	end

	tvsg_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.item   (item_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			out_q <= result;
	end

	assign rsp.valid   = out_valid_q;
	assign rsp.payload = out_q;

endmodule

>>> rtl/tvsg_checker.sv
// ----------------------------------------------------------------------------
// tvsg_checker
// Port-level checks of the sound generator: word ordering and occupancy.
// ----------------------------------------------------------------------------
module tvsg_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input tvsg_pkg::out_item_t rsp_payload
);

	// words accepted but not yet delivered
	logic [2:0] pending_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + {2'b0, req_valid && req_ready}
				- {2'b0, rsp_valid && rsp_ready};
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
		else $error("stalled result word changed");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pending_q != 3'd0)
		else $error("result word with no word accepted");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd2)
		else $error("more words in flight than pipeline holds");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == 3'd0 |-> req_ready)
		else $error("empty pipeline refused a word");

endmodule

bind three_voice_sound_generator_top tvsg_checker u_tvsg_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_payload (rsp.payload)
);
